[rtl/mip_pkg.sv]
package mip_pkg;

  // image size bound for the patch counter
  localparam int unsigned IMAGE_HALFWORDS = 16384;
  localparam int unsigned PATCH_LIMIT_INT =
    (IMAGE_HALFWORDS < 32767) ? IMAGE_HALFWORDS : 32767;
  localparam int unsigned CNT_W = 15;
  localparam logic [CNT_W-1:0] PATCH_LIMIT = CNT_W'(PATCH_LIMIT_INT);

  // leading halfword pattern of a wide move-immediate pair
  localparam logic [15:0] LEAD_MASK    = 16'hfbf0;
  localparam logic [15:0] LEAD_PATTERN = 16'hf240;

  // result queue sizing
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MATCH   = 1'b0,
    CFG_REPLACE = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] code_halfword;
    logic        image_end;
  } in_t;

  typedef struct packed {
    logic [15:0]      out_halfword;
    logic             out_last;
    logic [CNT_W-1:0] patch_total;
  } out_t;

  // up to two results pushed per accepted request
  typedef struct packed {
    logic push0;
    logic push1;
    out_t ent0;
    out_t ent1;
  } push_t;

endpackage

[rtl/mip_front.sv]
module mip_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  mip_pkg::cfg_idx_e cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  mip_pkg::in_t      in_req_i,
  input  logic              accept_i,
  output mip_pkg::push_t    push_o
);

  logic [15:0]               match_q, replace_q;
  logic [15:0]               held_q;
  logic                      held_valid_q, held_lead_q;
  logic [mip_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]               h;
  logic                      cur_lead, pair, hit;
  logic [15:0]               imm, held_out, cur_out;
  logic                      take;

  assign take = in_valid_i & accept_i;
  assign h    = in_req_i.code_halfword;

  // classify the new halfword against the pending lead
  assign cur_lead = (h & mip_pkg::LEAD_MASK) == mip_pkg::LEAD_PATTERN;
  assign pair     = !cur_lead && held_valid_q && held_lead_q && !h[15];
  assign imm      = {held_q[3:0], held_q[10], h[14:12], h[7:0]};
  assign hit      = pair && (imm == match_q);

  // rewrite both halves with the replacement immediate
  assign held_out = hit ? {held_q[15:11], replace_q[11], held_q[9:4], replace_q[15:12]}
                        : held_q;
  assign cur_out  = hit ? {h[15], replace_q[10:8], h[11:8], replace_q[7:0]} : h;

  // saturating patch count
  always_comb begin
    cnt_d = cnt_q;
    if (hit && (cnt_q < mip_pkg::PATCH_LIMIT)) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // results of this request
  always_comb begin
    push_o.push0             = take & (held_valid_q | in_req_i.image_end);
    push_o.push1             = take & held_valid_q & in_req_i.image_end;
    push_o.ent0.out_halfword = held_valid_q ? held_out : cur_out;
    push_o.ent0.out_last     = !held_valid_q;
    push_o.ent0.patch_total  = cnt_d;
    push_o.ent1.out_halfword = cur_out;
    push_o.ent1.out_last     = 1'b1;
    push_o.ent1.patch_total  = cnt_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q   <= '0;
      replace_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        mip_pkg::CFG_MATCH:   match_q   <= cfg_data_i;
        mip_pkg::CFG_REPLACE: replace_q <= cfg_data_i;
        default:              ;
      endcase
    end
  end

  // delay stage and per-image counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= '0;
      held_valid_q <= 1'b0;
      held_lead_q  <= 1'b0;
      cnt_q        <= '0;
    end else if (take) begin
      if (in_req_i.image_end) begin
        held_q       <= '0;
        held_valid_q <= 1'b0;
        held_lead_q  <= 1'b0;
        cnt_q        <= '0;
      end else begin
        held_q       <= cur_out;
        held_valid_q <= 1'b1;
        held_lead_q  <= cur_lead;
        cnt_q        <= cnt_d;
      end
    end
  end

  // end of image leaves the delay stage empty and the count cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_req_i.image_end |=> !held_valid_q && (cnt_q == '0))
    else $error("image end did not clear front state");

  // a pending lead is always a held halfword
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_lead_q |-> held_valid_q && (cnt_q <= mip_pkg::PATCH_LIMIT))
    else $error("front state inconsistent");

endmodule

[rtl/mip_queue.sv]
module mip_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  mip_pkg::push_t push_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mip_pkg::out_t  out_req_o
);

  mip_pkg::out_t                  mem_q [mip_pkg::Q_DEPTH];
  logic [mip_pkg::Q_PTR_W-1:0]    wr_q, rd_q, wr_p1;
  logic [mip_pkg::Q_CNT_W-1:0]    cnt_q, n_push;
  logic                           pop;

  assign out_valid_o = cnt_q != '0;
  assign out_req_o   = mem_q[rd_q];
  assign pop         = out_valid_o & !out_stall_i;
  // room for two results is needed before taking a request
  assign full_o      = cnt_q > mip_pkg::Q_CNT_W'(mip_pkg::Q_DEPTH - 2);
  assign wr_p1       = wr_q + 1'b1;
  assign n_push      = mip_pkg::Q_CNT_W'(push_i.push0) + mip_pkg::Q_CNT_W'(push_i.push1);

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.push0) begin
      mem_q[wr_q] <= push_i.ent0;
    end
    if (push_i.push1) begin
      mem_q[wr_p1] <= push_i.ent1;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + mip_pkg::Q_PTR_W'(n_push);
      rd_q  <= rd_q + mip_pkg::Q_PTR_W'(pop);
      cnt_q <= cnt_q + n_push - mip_pkg::Q_CNT_W'(pop);
    end
  end

  // never overfilled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mip_pkg::Q_CNT_W'(mip_pkg::Q_DEPTH))
    else $error("result queue overflow");

  // no push while the queue reports no room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.push0 && !push_i.push1)
    else $error("push into full result queue");

endmodule

[rtl/movw_immediate_patcher.sv]
// Streams a code image one 16-bit halfword per request and rewrites the
// immediate of wide move-immediate pairs whose value equals match_value.
// Output runs one halfword behind input; the last halfword of an image is
// delivered together with the held one, so an image-end request that finds a
// held halfword yields two results. A request is taken every cycle while the
// four-entry result queue has two free slots; results leave at one per cycle
// while out_stall_i is low, so a steady stream runs at one halfword per cycle
// and in_stall_o rises only when the output side stalls. Configuration writes
// are always ready and take effect on the next request.
module movw_immediate_patcher (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  mip_pkg::cfg_idx_e cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mip_pkg::in_t      in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mip_pkg::out_t     out_req_o
);

  mip_pkg::push_t push;
  logic           full;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  // front: classify and patch
  mip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .accept_i    (!full),
    .push_o      (push)
  );

  // back: result queue and output handshake
  mip_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

[sim/movw_immediate_patcher_tb.sv]
module movw_immediate_patcher_tb;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned HOLD_LEN     = 60;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS  = 30;
  localparam int unsigned IDLE_PCT     = 15;
  localparam int unsigned END_PCT      = 3;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  mip_pkg::cfg_idx_e cfg_idx_i;
  logic [15:0]       cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  mip_pkg::in_t      in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  mip_pkg::out_t     out_req_o;

  // predictor copy of the block state and its registers
  logic [15:0]               match_imm;
  logic [15:0]               replace_imm;
  logic [15:0]               delay_word;
  logic                      delay_full;
  logic                      delay_is_lead;
  logic [mip_pkg::CNT_W-1:0] image_patches;

  // halfwords still owed by the block, oldest first
  mip_pkg::out_t pending_words[$];

  int unsigned fail_count;
  int unsigned halfwords_sent;
  int unsigned images_sent;
  int unsigned patches_predicted;
  int unsigned words_checked;
  int unsigned cycle_count;
  int unsigned holds_asked;
  int unsigned holds_served;
  logic        quiet_mode = 1'b0;

  movw_immediate_patcher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o)
  );

  always #5 clk_i = ~clk_i;

  // leading and second half of a wide move carrying a given immediate
  function automatic logic [15:0] lead_of(input logic [15:0] imm);
    return mip_pkg::LEAD_PATTERN | {5'b0, imm[11], 6'b0, imm[15:12]};
  endfunction

  function automatic logic [15:0] tail_of(input logic [15:0] imm, input logic [3:0] rd);
    return {1'b0, imm[10:8], rd, imm[7:0]};
  endfunction

  function automatic logic rand_end();
    return $urandom_range(99) < END_PCT;
  endfunction

  // queue one expected halfword, tagged with the running patch count
  task automatic push_expected(input logic [15:0] word, input logic last);
    mip_pkg::out_t exp_word;
    exp_word.out_halfword = word;
    exp_word.out_last     = last;
    exp_word.patch_total  = image_patches;
    pending_words.push_back(exp_word);
  endtask

  // expected results of one accepted request
  task automatic predict_patch(input mip_pkg::in_t req);
    logic [15:0] word;
    logic [15:0] lead;
    logic [15:0] imm;
    logic        lead_now;
    word     = req.code_halfword;
    lead_now = (word & mip_pkg::LEAD_MASK) == mip_pkg::LEAD_PATTERN;
    if (lead_now) begin
      // a new lead pushes out whatever was held, pending lead or not
      if (delay_full) push_expected(delay_word, 1'b0);
    end else if (delay_full && delay_is_lead && !word[15]) begin
      lead = delay_word;
      imm  = {lead[3:0], lead[10], word[14:12], word[7:0]};
      if (imm == match_imm) begin
        lead = {lead[15:11], replace_imm[11], lead[9:4], replace_imm[15:12]};
        word = {word[15], replace_imm[10:8], word[11:8], replace_imm[7:0]};
        patches_predicted++;
        if (image_patches < mip_pkg::PATCH_LIMIT) image_patches++;
      end
      push_expected(lead, 1'b0);
    end else if (delay_full) begin
      push_expected(delay_word, 1'b0);
    end
    delay_word    = word;
    delay_full    = 1'b1;
    delay_is_lead = lead_now;
    if (req.image_end) begin
      push_expected(word, 1'b1);
      images_sent++;
      delay_word    = '0;
      delay_full    = 1'b0;
      delay_is_lead = 1'b0;
      image_patches = '0;
    end
  endtask

  // offer one request and wait until the block takes it
  task automatic send_halfword(input logic [15:0] word, input logic last);
    mip_pkg::in_t req;
    req.code_halfword = word;
    req.image_end     = last;
    while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_patch(req);
    halfwords_sent++;
  endtask

  task automatic send_pair(input logic [15:0] imm, input logic [3:0] rd, input logic last);
    send_halfword(lead_of(imm), 1'b0);
    send_halfword(tail_of(imm, rd), last);
  endtask

  // stop offering and let every owed result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input mip_pkg::cfg_idx_e idx, input logic [15:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      mip_pkg::CFG_MATCH: begin
        match_imm = val;
      end
      mip_pkg::CFG_REPLACE: begin
        replace_imm = val;
      end
      default: begin
      end
    endcase
  endtask

  task automatic set_patch_values(input logic [15:0] match_val, input logic [15:0] repl_val);
    write_reg(mip_pkg::CFG_MATCH, match_val);
    write_reg(mip_pkg::CFG_REPLACE, repl_val);
  endtask

  // hand-picked pairs covering each corner of the pair matching
  task automatic test_directed_pairs();
    set_patch_values(16'h1234, 16'habcd);
    send_pair(16'h1234, 4'd5, 1'b0);
    send_pair(16'h1235, 4'd0, 1'b0);
    // lead after lead: older lead passes untouched
    send_halfword(lead_of(16'h1234), 1'b0);
    send_pair(16'h1234, 4'd15, 1'b0);
    // second half with bit 15 set breaks the pair
    send_halfword(lead_of(16'h1234), 1'b0);
    send_halfword(tail_of(16'h1234, 4'd7) | 16'h8000, 1'b0);
    send_halfword(16'h0000, 1'b0);
    send_halfword(16'hffff, 1'b0);
    // lead as the last halfword of an image
    send_halfword(lead_of(16'h1234), 1'b1);
    // one-halfword image
    send_halfword(16'hffff, 1'b1);
    // nothing held yet, so no output for the first request
    send_halfword(16'h0000, 1'b0);
    send_pair(16'h1234, 4'd3, 1'b1);
  endtask

  // match and replace values at both ends of their range
  task automatic test_config_extremes();
    set_patch_values(16'hffff, 16'h0000);
    send_pair(16'hffff, 4'd9, 1'b0);
    send_pair(16'hfffe, 4'd1, 1'b1);
    set_patch_values(16'h0000, 16'hffff);
    send_pair(16'h0000, 4'd2, 1'b0);
    send_pair(16'h0001, 4'd14, 1'b1);
  endtask

  // output held off while input keeps coming, then a full drain
  task automatic test_backpressure();
    quiet_mode = 1'b1;
    holds_asked++;
    repeat (12) send_pair(match_imm, 4'($urandom), 1'($urandom_range(1)));
    drain_results();
    quiet_mode = 1'b0;
  endtask

  // mostly well-formed pairs with random content, some broken ones and noise
  task automatic test_random_stream(input int unsigned count);
    int unsigned first;
    int unsigned pick;
    logic [15:0] imm;
    logic [3:0]  rd;
    first = halfwords_sent;
    while (halfwords_sent - first < count) begin
      pick = $urandom_range(99);
      imm  = ($urandom_range(99) < 60) ? match_imm : 16'($urandom);
      rd   = 4'($urandom);
      if (pick < 50) begin
        send_halfword(lead_of(imm), rand_end());
        send_halfword(tail_of(imm, rd), rand_end());
      end else if (pick < 60) begin
        send_halfword(lead_of(16'($urandom)), rand_end());
        send_halfword(lead_of(imm), rand_end());
        send_halfword(tail_of(imm, rd), rand_end());
      end else if (pick < 70) begin
        send_halfword(lead_of(imm), rand_end());
        send_halfword(tail_of(imm, rd) | 16'h8000, rand_end());
      end else begin
        send_halfword(16'($urandom), rand_end());
      end
    end
  endtask

  task automatic flag_mismatch(input string field, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
  endtask

  // output stall: random, silent in quiet stretches, long hold on request
  initial begin : out_stall_gen
    int unsigned hold_left;
    hold_left    = 0;
    holds_served = 0;
    out_stall_i  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left == 0 && holds_served != holds_asked) begin
        hold_left = HOLD_LEN;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // compare every accepted result with the oldest expected one
  always @(posedge clk_i) begin : result_check
    mip_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $error("unexpected result 0x%0h with nothing outstanding", out_req_o);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_req_o.out_halfword !== want.out_halfword)
          flag_mismatch("out_halfword", want.out_halfword, out_req_o.out_halfword);
        if (out_req_o.out_last !== want.out_last)
          flag_mismatch("out_last", want.out_last, out_req_o.out_last);
        if (out_req_o.patch_total !== want.patch_total)
          flag_mismatch("patch_total", want.patch_total, out_req_o.patch_total);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("movw_immediate_patcher verification failed");
    $finish;
  end

  initial begin : test_sequence
    rst_ni            = 1'b0;
    cfg_valid_i       = 1'b0;
    cfg_idx_i         = mip_pkg::CFG_MATCH;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    in_req_i          = '0;
    match_imm         = '0;
    replace_imm       = '0;
    delay_word        = '0;
    delay_full        = 1'b0;
    delay_is_lead     = 1'b0;
    image_patches     = '0;
    fail_count        = 0;
    halfwords_sent    = 0;
    images_sent       = 0;
    patches_predicted = 0;
    words_checked     = 0;
    holds_asked       = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_pairs();
    test_config_extremes();
    test_backpressure();
    set_patch_values(16'($urandom), 16'($urandom));
    test_random_stream(400);
    quiet_mode = 1'b1;
    test_random_stream(300);
    quiet_mode = 1'b0;
    set_patch_values(16'hffff, 16'hffff);
    test_random_stream(300);
    set_patch_values(16'h0000, 16'h0000);
    test_random_stream(300);
    set_patch_values(16'($urandom), 16'($urandom));
    test_random_stream(300);
    drain_results();

    $display("stream of %0d halfwords in %0d images, %0d results compared",
             halfwords_sent, images_sent, words_checked);
    $display("%0d pairs rewritten, with broken pairs, lead after lead and short images",
             patches_predicted);
    if (fail_count == 0) begin
      $display("movw_immediate_patcher verification clean");
    end else begin
      $display("movw_immediate_patcher verification failed");
    end
    $finish;
  end

endmodule
